>>> rtl/wvsd_pkg.sv
// Shared types and constants for the wind vector to speed/direction CORDIC.
package wvsd_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int WORK_FRAC = 14;
    localparam int ANG_FRAC  = 10;
    // x/y carry the input << 14 and grow by the CORDIC gain; 34 bits covers it.
    localparam int XW        = 34;
    // Angle in 1/100 degree << 10: |z| stays below 2^25.
    localparam int ZW        = 27;
    localparam int HW        = ZW - ANG_FRAC;
    localparam int TABLE_LEN = 24;

    localparam int GAIN_W    = 30;
    localparam int MAG_W     = 31;
    localparam int PROD_W    = MAG_W + GAIN_W;
    localparam int SPD_SHIFT = 44;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

    localparam logic signed [ZW-1:0] HALF_TURN_Z = 27'sd18432000;   // 18000 << 10
    localparam logic signed [HW-1:0] HALF_TURN   = 17'sd18000;
    localparam logic signed [HW-1:0] FULL_TURN   = 17'sd36000;

    // atan(2^-i) in 1/100 degree << 10, rounded to nearest
    localparam logic signed [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
        27'sd4608000, 27'sd2720261, 27'sd1437311, 27'sd729602,
        27'sd366217,  27'sd183287,  27'sd91666,   27'sd45836,
        27'sd22918,   27'sd11459,   27'sd5730,    27'sd2865,
        27'sd1432,    27'sd716,     27'sd358,     27'sd179,
        27'sd90,      27'sd45,      27'sd22,      27'sd11,
        27'sd6,       27'sd3,       27'sd1,       27'sd1
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } wvsd_vec_t;

endpackage

>>> rtl/wvsd_cell.sv
// One CORDIC vectoring micro-rotation cell with its own pipeline register.
module wvsd_cell #(
    parameter int SHIFT = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  wvsd_pkg::wvsd_vec_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output wvsd_pkg::wvsd_vec_t out_data
);
    import wvsd_pkg::*;

    logic                 valid_reg;
    wvsd_vec_t            data_reg;
    wvsd_vec_t            data_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    assign in_ready = ~valid_reg | out_ready;

    always_comb begin
        xs = in_data.x >>> SHIFT;
        ys = in_data.y >>> SHIFT;
        data_next.zero = in_data.zero;
        if (!in_data.y[XW-1]) begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + ATAN_TABLE[SHIFT];
        end else begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - ATAN_TABLE[SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/wvsd_post.sv
// Gain removal, rounding and heading wrap: two register stages after the cells.
module wvsd_post (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  wvsd_pkg::wvsd_vec_t          in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [wvsd_pkg::OUT_W-1:0]   out_speed,
    output logic signed [wvsd_pkg::OUT_W-1:0] out_heading
);
    import wvsd_pkg::*;

    localparam int SUM_W = PROD_W + 1;
    localparam int Q_W   = SUM_W - SPD_SHIFT;

    // stage A: multiply and heading
    logic                     a_valid_reg;
    logic                     a_ready;
    logic [PROD_W-1:0]        a_prod_reg;
    logic [PROD_W-1:0]        a_prod_next;
    logic signed [OUT_W-1:0]  a_head_reg;
    logic signed [OUT_W-1:0]  a_head_next;
    logic                     a_zero_reg;
    logic [MAG_W-1:0]         mag;
    logic signed [ZW-1:0]     z_rnd;
    logic signed [HW-1:0]     h_raw;
    logic signed [HW-1:0]     h_wrap;

    // stage B: round and saturate speed
    logic                     b_valid_reg;
    logic                     b_ready;
    logic [OUT_W-1:0]         b_speed_reg;
    logic [OUT_W-1:0]         b_speed_next;
    logic signed [OUT_W-1:0]  b_head_reg;
    logic [SUM_W-1:0]         sum;
    logic [Q_W-1:0]           q;

    assign b_ready  = ~b_valid_reg | out_ready;
    assign a_ready  = ~a_valid_reg | b_ready;
    assign in_ready = a_ready;

    always_comb begin
        mag = in_data.x[XW-1] ? '0 : in_data.x[MAG_W-1:0];
        a_prod_next = PROD_W'(mag) * PROD_W'(GAIN_Q30);
        z_rnd  = in_data.z + ZW'(1 << (ANG_FRAC - 1));
        h_raw  = z_rnd[ZW-1:ANG_FRAC];
        if (h_raw <= -HALF_TURN) begin
            h_wrap = h_raw + FULL_TURN;
        end else if (h_raw > HALF_TURN) begin
            h_wrap = h_raw - FULL_TURN;
        end else begin
            h_wrap = h_raw;
        end
        a_head_next = in_data.zero ? '0 : h_wrap[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_prod_reg <= a_prod_next;
            a_head_reg <= a_head_next;
            a_zero_reg <= in_data.zero;
        end
    end

    always_comb begin
        sum = {1'b0, a_prod_reg} + (SUM_W'(1) << (SPD_SHIFT - 1));
        q   = sum[SUM_W-1:SPD_SHIFT];
        if (a_zero_reg) begin
            b_speed_next = '0;
        end else if (|q[Q_W-1:OUT_W]) begin
            b_speed_next = '1;
        end else begin
            b_speed_next = q[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_speed_reg <= b_speed_next;
            b_head_reg  <= a_head_reg;
        end
    end

    assign out_valid   = b_valid_reg;
    assign out_speed   = b_speed_reg;
    assign out_heading = b_head_reg;

endmodule

>>> rtl/wind_vector_to_speed_direction.sv
// Top level: wind vector (u, v) to speed and heading by a pipelined CORDIC.
//
// Converts one wind vector per beat, u eastward and v northward as signed
// 1/256 m/s, into speed sqrt(u^2+v^2) in 1/256 m/s and heading atan2(v,u) in
// hundredths of a degree over (-18000, 18000]. A new beat is taken every
// clock cycle while the output is not stalled; each beat passes through one
// quadrant-folding register, one register per micro-rotation cell, then a
// gain-multiply stage and a rounding stage. Every stage has its own valid bit
// and is ready when empty or when the stage after it moves, so bubbles
// collapse and input keeps flowing while a finished result waits at the
// output. Zero vectors give speed 0 and heading 0. No configuration, no
// state between beats.
module wind_vector_to_speed_direction #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [wvsd_pkg::IN_W-1:0] s_u_component,
    input  logic signed [wvsd_pkg::IN_W-1:0] s_v_component,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [wvsd_pkg::OUT_W-1:0]       m_speed,
    output logic signed [wvsd_pkg::OUT_W-1:0] m_heading
);
    import wvsd_pkg::*;

    // stage 0 is the fold register, stage k+1 the output of cell k
    wvsd_vec_t stage_data [CORDIC_STAGES+1];
    logic      stage_vld  [CORDIC_STAGES+1];
    logic      stage_rdy  [CORDIC_STAGES+1];

    logic                 fold_valid_reg;
    wvsd_vec_t            fold_reg;
    wvsd_vec_t            fold_next;
    logic signed [XW-1:0] u_ext;
    logic signed [XW-1:0] v_ext;

    // Fold left half plane into the right by a 180 degree turn; the angle
    // starts at +/-180 depending on the sign of v.
    always_comb begin
        u_ext = XW'(s_u_component);
        v_ext = XW'(s_v_component);
        fold_next.zero = (s_u_component == '0) && (s_v_component == '0);
        if (s_u_component[IN_W-1]) begin
            fold_next.x = (-u_ext) <<< WORK_FRAC;
            fold_next.y = (-v_ext) <<< WORK_FRAC;
            fold_next.z = s_v_component[IN_W-1] ? -HALF_TURN_Z : HALF_TURN_Z;
        end else begin
            fold_next.x = u_ext <<< WORK_FRAC;
            fold_next.y = v_ext <<< WORK_FRAC;
            fold_next.z = '0;
        end
    end

    assign s_ready = ~fold_valid_reg | stage_rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
        end else if (s_ready) begin
            fold_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            fold_reg <= fold_next;
        end
    end

    assign stage_data[0] = fold_reg;
    assign stage_vld[0]  = fold_valid_reg;

    // chain of micro-rotation cells
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        wvsd_cell #(
            .SHIFT (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_vld[k]),
            .in_ready  (stage_rdy[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_vld[k+1]),
            .out_ready (stage_rdy[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    wvsd_post u_post (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (stage_vld[CORDIC_STAGES]),
        .in_ready    (stage_rdy[CORDIC_STAGES]),
        .in_data     (stage_data[CORDIC_STAGES]),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_speed   (m_speed),
        .out_heading (m_heading)
    );

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the wind vector to speed/heading CORDIC block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wvsd_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int STAGES        = 16;
    localparam int LUT_LEN       = 24;
    localparam int IN_FRAC       = 14;            // x/y carry input << 14
    localparam int ANG_SHIFT     = 10;            // z in 1/100 deg << 10
    localparam longint SPEED_GAIN = 652032874;    // 1/K in Q30
    localparam int SPEED_SHIFT   = 44;            // Q14 work * Q30 gain
    localparam int HALF_TURN_CDEG = 18000;
    localparam int FULL_TURN_CDEG = 36000;
    localparam int SPEED_MAX     = 65535;

    localparam int RANDOM_BEATS  = 1230;
    localparam int QUIET_TAIL    = 150;           // last beats run without idling
    localparam int STALL_LIMIT   = 2000;          // cycles with no beat on either side
    localparam int DRAIN_CYCLES  = STAGES + 3 + 8;

    // atan(2^-i), 1/100 degree scaled by 2^10, rounded to nearest
    localparam longint ARCTAN_LUT [LUT_LEN] = '{
        4608000, 2720261, 1437311, 729602, 366217, 183287, 91666, 45836,
        22918, 11459, 5730, 2865, 1432, 716, 358, 179,
        90, 45, 22, 11, 6, 3, 1, 1
    };

    // One input vector, with an optional hand-typed answer.
    typedef struct packed {
        logic signed [IN_W-1:0]  u;
        logic signed [IN_W-1:0]  v;
        logic                    typed;
        logic [OUT_W-1:0]        speed;
        logic signed [OUT_W-1:0] heading;
    } wind_row_t;

    // Expected speed/heading, with the vector kept for messages.
    typedef struct packed {
        logic signed [IN_W-1:0]  u;
        logic signed [IN_W-1:0]  v;
        logic [OUT_W-1:0]        speed;
        logic signed [OUT_W-1:0] heading;
    } polar_t;

    // Directed vectors: zero vector, axes, extremes, both half planes, and
    // vectors just below the negative u axis whose heading lands on -180
    // and must come back as +180. Only the zero vector is typed in.
    localparam int N_DIRECTED = 24;
    localparam wind_row_t DIRECTED [N_DIRECTED] = '{
        '{16'sd0,       16'sd0,       1'b1, 16'd0, 16'sd0},
        '{16'sh7FFF,    16'sd0,       1'b0, 16'd0, 16'sd0},
        '{16'sh8000,    16'sd0,       1'b0, 16'd0, 16'sd0},
        '{16'sd0,       16'sh7FFF,    1'b0, 16'd0, 16'sd0},
        '{16'sd0,       16'sh8000,    1'b0, 16'd0, 16'sd0},
        '{16'sh7FFF,    16'sh7FFF,    1'b0, 16'd0, 16'sd0},
        '{16'sh8000,    16'sh8000,    1'b0, 16'd0, 16'sd0},
        '{16'sh8000,    16'sh7FFF,    1'b0, 16'd0, 16'sd0},
        '{16'sh7FFF,    16'sh8000,    1'b0, 16'd0, 16'sd0},
        '{16'sd1,       16'sd0,       1'b0, 16'd0, 16'sd0},
        '{-16'sd1,      16'sd0,       1'b0, 16'd0, 16'sd0},
        '{16'sd0,       16'sd1,       1'b0, 16'd0, 16'sd0},
        '{16'sd0,       -16'sd1,      1'b0, 16'd0, 16'sd0},
        '{16'sd1,       16'sd1,       1'b0, 16'd0, 16'sd0},
        '{16'sd1,       -16'sd1,      1'b0, 16'd0, 16'sd0},
        '{-16'sd1,      16'sd1,       1'b0, 16'd0, 16'sd0},
        '{-16'sd1,      -16'sd1,      1'b0, 16'd0, 16'sd0},
        '{16'sh8000,    -16'sd1,      1'b0, 16'd0, 16'sd0},
        '{16'sh8000,    16'sd1,       1'b0, 16'd0, 16'sd0},
        '{-16'sd20000,  -16'sd1,      1'b0, 16'd0, 16'sd0},
        '{-16'sd5,      16'sd0,       1'b0, 16'd0, 16'sd0},
        '{16'sh5555,    16'shAAAA,    1'b0, 16'd0, 16'sd0},
        '{16'shAAAA,    16'sh5555,    1'b0, 16'd0, 16'sd0},
        '{16'sd0,       16'sd0,       1'b1, 16'd0, 16'sd0}
    };

    localparam logic signed [IN_W-1:0] RAIL_VALUES [6] = '{
        16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF
    };

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic signed [IN_W-1:0]  s_u_component = '0;
    logic signed [IN_W-1:0]  s_v_component = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic [OUT_W-1:0]        m_speed;
    logic signed [OUT_W-1:0] m_heading;

    wind_vector_to_speed_direction #(
        .CORDIC_STAGES(STAGES)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_u_component (s_u_component),
        .s_v_component (s_v_component),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_speed       (m_speed),
        .m_heading     (m_heading)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    wind_row_t vector_q [$];      // vectors still to be driven
    polar_t    pending_polar [$]; // expected results, oldest first
    int        total_vectors = 0;
    int        vectors_taken = 0;
    int        results_seen  = 0;
    int        mismatch_cnt  = 0;

    // ------------------------------------------------------------------
    // Predictor: CORDIC vectoring in 64-bit integer arithmetic.
    // Signed >>> on longint floors, as the block's shifts do.
    // ------------------------------------------------------------------
    function automatic polar_t polar_of(logic signed [IN_W-1:0] u,
                                        logic signed [IN_W-1:0] v);
        polar_t r;
        longint x, y, z, xs, ys, spd, hd;
        int     k;
        r.u = u;
        r.v = v;
        if (u == 0 && v == 0) begin
            r.speed   = '0;
            r.heading = '0;
            return r;
        end
        // left half plane: rotate by 180 deg, preload +/-180 into the angle
        if (u < 0) begin
            x = -longint'(u);
            y = -longint'(v);
            z = longint'((v >= 0) ? HALF_TURN_CDEG : -HALF_TURN_CDEG) <<< ANG_SHIFT;
        end else begin
            x = longint'(u);
            y = longint'(v);
            z = 0;
        end
        x = x <<< IN_FRAC;
        y = y <<< IN_FRAC;
        for (k = 0; k < STAGES && k < LUT_LEN; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_LUT[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_LUT[k];
            end
        end
        if (x < 0)
            x = 0;
        // fits in 63 bits: x < 2^31, gain < 2^30
        spd = (x * SPEED_GAIN + (longint'(1) <<< (SPEED_SHIFT - 1))) >>> SPEED_SHIFT;
        if (spd > SPEED_MAX)
            spd = SPEED_MAX;
        hd = (z + (longint'(1) <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
        while (hd <= -HALF_TURN_CDEG)
            hd = hd + FULL_TURN_CDEG;
        while (hd > HALF_TURN_CDEG)
            hd = hd - FULL_TURN_CDEG;
        r.speed   = spd[OUT_W-1:0];
        r.heading = hd[OUT_W-1:0];
        return r;
    endfunction

    // Random vector drawn from a few shapes: full range, tiny magnitudes,
    // near an axis, rails, near the -180 seam, and exact diagonals.
    function automatic wind_row_t random_vector();
        wind_row_t w;
        int        pick;
        logic signed [IN_W-1:0] mag;
        w       = '0;
        pick    = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: begin
                w.u = IN_W'($urandom);
                w.v = IN_W'($urandom);
            end
            4, 5: begin
                w.u = IN_W'($urandom_range(0, 63) - 32);
                w.v = IN_W'($urandom_range(0, 63) - 32);
            end
            6: begin
                if ($urandom_range(0, 1) == 1) begin
                    w.u = IN_W'($urandom_range(0, 2) - 1);
                    w.v = IN_W'($urandom);
                end else begin
                    w.u = IN_W'($urandom);
                    w.v = IN_W'($urandom_range(0, 2) - 1);
                end
            end
            7: begin
                w.u = RAIL_VALUES[$urandom_range(0, 5)];
                w.v = RAIL_VALUES[$urandom_range(0, 5)];
            end
            8: begin
                // just around the negative u axis
                w.u = IN_W'(-$urandom_range(1, 32768));
                w.v = IN_W'($urandom_range(0, 7) - 4);
            end
            default: begin
                mag = IN_W'($urandom_range(0, 32767));
                w.u = ($urandom_range(0, 1) == 1) ? -mag : mag;
                w.v = ($urandom_range(0, 1) == 1) ? -mag : mag;
            end
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one beat per handshake, random idle bursts in some
    // stretches, no idling in the last QUIET_TAIL beats.
    // ------------------------------------------------------------------
    wind_row_t cur_vector;
    int        src_gap  = 0;
    bit        src_calm = 1'b0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (cur_vector.typed)
                    pending_polar.push_back('{cur_vector.u, cur_vector.v,
                                              cur_vector.speed, cur_vector.heading});
                else
                    pending_polar.push_back(polar_of(cur_vector.u, cur_vector.v));
                vectors_taken++;
                if (vectors_taken % 100 == 0)
                    src_calm = ($urandom_range(0, 3) == 0);
            end
            // valid holds until the beat is taken; otherwise pick the next move
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (vector_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!src_calm && vector_q.size() > QUIET_TAIL &&
                             $urandom_range(0, 4) == 0) begin
                    src_gap = $urandom_range(1, 4) - 1;
                    s_valid <= 1'b0;
                end else begin
                    cur_vector = vector_q.pop_front();
                    s_valid       <= 1'b1;
                    s_u_component <= cur_vector.u;
                    s_v_component <= cur_vector.v;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: compare each beat with the oldest expectation, and
    // stall m_ready in random bursts.
    // ------------------------------------------------------------------
    int sink_gap  = 0;
    bit sink_calm = 1'b0;

    always @(posedge aclk) begin
        polar_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (results_seen % 100 == 0)
                    sink_calm = ($urandom_range(0, 3) == 0);
                if (pending_polar.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result: speed %0d heading %0d",
                             $time, m_speed, m_heading);
                end else begin
                    want = pending_polar.pop_front();
                    if (m_speed !== want.speed) begin
                        mismatch_cnt++;
                        $display("%0t: speed mismatch u=%0d v=%0d: expected %0d, actual %0d",
                                 $time, want.u, want.v, want.speed, m_speed);
                    end
                    if (m_heading !== want.heading) begin
                        mismatch_cnt++;
                        $display("%0t: heading mismatch u=%0d v=%0d: expected %0d, actual %0d",
                                 $time, want.u, want.v, want.heading, m_heading);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (!sink_calm && vector_q.size() > QUIET_TAIL &&
                         $urandom_range(0, 4) == 0) begin
                sink_gap = $urandom_range(1, 4) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no beat on either channel ends the run.
    // ------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: load vectors, reset, wait for the last result, drain.
    // ------------------------------------------------------------------
    initial begin
        int n;
        for (n = 0; n < N_DIRECTED; n++)
            vector_q.push_back(DIRECTED[n]);
        for (n = 0; n < RANDOM_BEATS; n++)
            vector_q.push_back(random_vector());
        total_vectors = vector_q.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // done once every vector is taken and every result has come back
        while (vectors_taken != total_vectors || pending_polar.size() != 0)
            @(posedge aclk);
        // give a stray extra beat time to show up
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
